// ----- rtl/lis_pkg.sv -----
// Shared constants and control types for the longest increasing subsequence block.
package lis_pkg;

  localparam int unsigned MaxItems = 64;
  localparam int unsigned ValW     = 32;
  localparam int unsigned CntW     = 7;
  localparam int unsigned IdxW     = 6;

  typedef logic signed [ValW-1:0] val_t;
  typedef logic [CntW-1:0]        cnt_t;
  typedef logic [IdxW-1:0]        idx_t;

  typedef struct packed {
    logic accept;
    logic scan;
    logic store;
    logic walk_start;
    logic walk_wr;
    logic out_start;
    logic out_ld;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic scan_done;
    logic walk_last;
    logic out_done;
  } status_t;

endpackage

// ----- rtl/lis_in_if.sv -----
// Input channel: one sequence value per beat, with end-of-sequence flag.
interface lis_in_if;
  logic               valid;
  logic               ready;
  lis_pkg::val_t      value;
  logic               is_final;

  modport source (output valid, output value, output is_final, input ready);
  modport sink   (input valid, input value, input is_final, output ready);
endinterface

// ----- rtl/lis_out_if.sv -----
// Output channel: one subsequence member per beat, with last flag and length.
interface lis_out_if;
  logic               valid;
  logic               ready;
  lis_pkg::val_t      element;
  logic               final_element;
  lis_pkg::cnt_t      run_length;

  modport source (output valid, output element, output final_element, output run_length,
                  input ready);
  modport sink   (input valid, input element, input final_element, input run_length,
                  output ready);
endinterface

// ----- rtl/lis_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
module lis_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/lis_dp.sv -----
// Datapath: value, chain length, predecessor and path memories with scan and walk logic.
module lis_dp (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  lis_pkg::cmd_t       cmd_i,
  output lis_pkg::status_t    status_o,
  input  lis_pkg::val_t       value_i,
  output lis_pkg::val_t       element_o,
  output logic                final_element_o,
  output lis_pkg::cnt_t       run_length_o
);

  lis_pkg::cnt_t count_q, count_d;
  lis_pkg::cnt_t k_q, k_d;
  lis_pkg::cnt_t best_q, best_d;
  lis_pkg::idx_t link_q, link_d;
  lis_pkg::cnt_t max_len_q, max_len_d;
  lis_pkg::idx_t max_pos_q, max_pos_d;
  lis_pkg::idx_t walk_idx_q, walk_idx_d;
  lis_pkg::idx_t walk_pos_q, walk_pos_d;
  lis_pkg::cnt_t out_idx_q, out_idx_d;
  logic          cmp_vld_q, cmp_vld_d;
  lis_pkg::idx_t cmp_idx_q, cmp_idx_d;
  lis_pkg::val_t v_q, v_d;
  lis_pkg::val_t elem_q, elem_d;
  logic          fin_el_q, fin_el_d;

  lis_pkg::cnt_t k_m1;
  lis_pkg::cnt_t new_len;
  lis_pkg::cnt_t out_idx_p1;
  lis_pkg::idx_t rd_addr;
  lis_pkg::val_t val_rd;
  lis_pkg::cnt_t chain_rd;
  lis_pkg::idx_t pred_rd;
  lis_pkg::val_t path_rd;

  assign k_m1       = k_q - lis_pkg::CntW'(1);
  assign new_len    = best_q + lis_pkg::CntW'(1);
  assign out_idx_p1 = out_idx_q + lis_pkg::CntW'(1);
  assign rd_addr    = cmd_i.scan ? k_m1[lis_pkg::IdxW-1:0] : walk_idx_q;

  lis_ram #(.Width(lis_pkg::ValW), .Depth(lis_pkg::MaxItems)) u_value_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.store),
    .waddr_i (count_q[lis_pkg::IdxW-1:0]),
    .wdata_i (v_q),
    .raddr_i (rd_addr),
    .rdata_o (val_rd)
  );

  lis_ram #(.Width(lis_pkg::CntW), .Depth(lis_pkg::MaxItems)) u_chain_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.store),
    .waddr_i (count_q[lis_pkg::IdxW-1:0]),
    .wdata_i (new_len),
    .raddr_i (rd_addr),
    .rdata_o (chain_rd)
  );

  lis_ram #(.Width(lis_pkg::IdxW), .Depth(lis_pkg::MaxItems)) u_pred_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.store),
    .waddr_i (count_q[lis_pkg::IdxW-1:0]),
    .wdata_i (link_q),
    .raddr_i (walk_idx_q),
    .rdata_o (pred_rd)
  );

  lis_ram #(.Width(lis_pkg::ValW), .Depth(lis_pkg::MaxItems)) u_path_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.walk_wr),
    .waddr_i (walk_pos_q),
    .wdata_i (val_rd),
    .raddr_i (out_idx_q[lis_pkg::IdxW-1:0]),
    .rdata_o (path_rd)
  );

  always_comb begin
    count_d    = count_q;
    k_d        = k_q;
    best_d     = best_q;
    link_d     = link_q;
    max_len_d  = max_len_q;
    max_pos_d  = max_pos_q;
    walk_idx_d = walk_idx_q;
    walk_pos_d = walk_pos_q;
    out_idx_d  = out_idx_q;
    cmp_vld_d  = 1'b0;
    cmp_idx_d  = cmp_idx_q;
    v_d        = v_q;
    elem_d     = elem_q;
    fin_el_d   = fin_el_q;

    if (cmd_i.accept) begin
      v_d    = value_i;
      k_d    = count_q;
      best_d = '0;
      link_d = '0;
    end
    if (cmd_i.scan && (k_q != '0)) begin
      k_d       = k_m1;
      cmp_vld_d = 1'b1;
      cmp_idx_d = k_m1[lis_pkg::IdxW-1:0];
    end
    if (cmp_vld_q && (chain_rd > best_q) && (val_rd < v_q)) begin
      best_d = chain_rd;
      link_d = cmp_idx_q;
    end
    if (cmd_i.store) begin
      count_d = count_q + lis_pkg::CntW'(1);
      if (new_len > max_len_q) begin
        max_len_d = new_len;
        max_pos_d = count_q[lis_pkg::IdxW-1:0];
      end
    end
    if (cmd_i.walk_start) begin
      walk_idx_d = max_pos_q;
      walk_pos_d = max_len_q[lis_pkg::IdxW-1:0] - lis_pkg::IdxW'(1);
    end
    if (cmd_i.walk_wr) begin
      walk_idx_d = pred_rd;
      walk_pos_d = walk_pos_q - lis_pkg::IdxW'(1);
    end
    if (cmd_i.out_start) begin
      out_idx_d = '0;
    end
    if (cmd_i.out_ld) begin
      elem_d    = path_rd;
      fin_el_d  = (out_idx_p1 == max_len_q);
      out_idx_d = out_idx_p1;
    end
    if (cmd_i.finish) begin
      count_d   = '0;
      max_len_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q   <= '0;
      max_len_q <= '0;
      k_q       <= '0;
      out_idx_q <= '0;
      cmp_vld_q <= 1'b0;
    end else begin
      count_q   <= count_d;
      max_len_q <= max_len_d;
      k_q       <= k_d;
      out_idx_q <= out_idx_d;
      cmp_vld_q <= cmp_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    best_q     <= best_d;
    link_q     <= link_d;
    max_pos_q  <= max_pos_d;
    walk_idx_q <= walk_idx_d;
    walk_pos_q <= walk_pos_d;
    cmp_idx_q  <= cmp_idx_d;
    v_q        <= v_d;
    elem_q     <= elem_d;
    fin_el_q   <= fin_el_d;
  end

  assign status_o.full      = (count_q == lis_pkg::CntW'(lis_pkg::MaxItems));
  assign status_o.scan_done = (k_q == '0) && !cmp_vld_q;
  assign status_o.walk_last = (walk_pos_q == '0);
  assign status_o.out_done  = (out_idx_q == max_len_q);

  assign element_o       = elem_q;
  assign final_element_o = fin_el_q;
  assign run_length_o    = max_len_q;

endmodule

// ----- rtl/lis_ctrl.sv -----
// Controller: sequences accept, scan, store, walk-back and emission phases.
module lis_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic             in_final_i,
  output logic             in_ready_o,
  input  logic             out_ready_i,
  output logic             out_valid_o,
  input  lis_pkg::status_t status_i,
  output lis_pkg::cmd_t    cmd_o
);

  typedef enum logic [3:0] {
    StIdle,
    StScan,
    StStore,
    StWalkSet,
    StWalkRd,
    StWalkWr,
    StOutRd,
    StOutLd,
    StOutHold
  } state_e;

  state_e state_q, state_d;
  logic   fin_q, fin_d;
  logic   in_ready_q, in_ready_d;
  logic   out_valid_q, out_valid_d;
  logic   in_beat;

  assign in_beat = in_valid_i && in_ready_q;

  always_comb begin
    state_d     = state_q;
    fin_d       = fin_q;
    in_ready_d  = 1'b0;
    out_valid_d = 1'b0;
    cmd_o       = '0;
    case (state_q)
      StIdle: begin
        in_ready_d = 1'b1;
        if (in_beat) begin
          fin_d      = in_final_i;
          in_ready_d = 1'b0;
          if (!status_i.full) begin
            cmd_o.accept = 1'b1;
            state_d      = StScan;
          end else if (in_final_i) begin
            state_d = StWalkSet;
          end else begin
            in_ready_d = 1'b1;
          end
        end
      end
      StScan: begin
        cmd_o.scan = 1'b1;
        if (status_i.scan_done) begin
          state_d = StStore;
        end
      end
      StStore: begin
        cmd_o.store = 1'b1;
        if (fin_q) begin
          state_d = StWalkSet;
        end else begin
          state_d    = StIdle;
          in_ready_d = 1'b1;
        end
      end
      StWalkSet: begin
        cmd_o.walk_start = 1'b1;
        state_d          = StWalkRd;
      end
      StWalkRd: begin
        state_d = StWalkWr;
      end
      StWalkWr: begin
        cmd_o.walk_wr = 1'b1;
        if (status_i.walk_last) begin
          cmd_o.out_start = 1'b1;
          state_d         = StOutRd;
        end else begin
          state_d = StWalkRd;
        end
      end
      StOutRd: begin
        state_d = StOutLd;
      end
      StOutLd: begin
        cmd_o.out_ld = 1'b1;
        out_valid_d  = 1'b1;
        state_d      = StOutHold;
      end
      StOutHold: begin
        out_valid_d = 1'b1;
        if (out_ready_i) begin
          out_valid_d = 1'b0;
          if (status_i.out_done) begin
            cmd_o.finish = 1'b1;
            state_d      = StIdle;
            in_ready_d   = 1'b1;
          end else begin
            state_d = StOutRd;
          end
        end
      end
      default: begin
        state_d    = StIdle;
        in_ready_d = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      fin_q       <= 1'b0;
      in_ready_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      fin_q       <= fin_d;
      in_ready_q  <= in_ready_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = in_ready_q;
  assign out_valid_o = out_valid_q;

endmodule

// ----- rtl/longest_increasing_subsequence.sv -----
// Top level: longest strictly increasing subsequence, quadratic scan with walk-back.
//
//   channel  dir  payload                                      beat
//   in_i     in   value[31:0] signed, is_final                 valid & ready
//   out_o    out  element[31:0] signed, final_element,         valid & ready
//                 run_length[6:0]
//
// Storing a value reads each of the values already held (up to 63), drains
// the compare, then writes the new entry. Values past 64 are dropped at one
// per cycle. A final beat adds a walk-back that writes each member into the
// path memory, then one result beat per member, each held while out_o.ready
// is low. Reset clears the count and control; in_i.ready rises in the cycle
// after reset.
module longest_increasing_subsequence (
  input  logic      clk_i,
  input  logic      rst_ni,
  lis_in_if.sink    in_i,
  lis_out_if.source out_o
);

  lis_pkg::cmd_t    cmd;
  lis_pkg::status_t status;

  lis_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_final_i  (in_i.is_final),
    .in_ready_o  (in_i.ready),
    .out_ready_i (out_o.ready),
    .out_valid_o (out_o.valid),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  lis_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .status_o        (status),
    .value_i         (in_i.value),
    .element_o       (out_o.element),
    .final_element_o (out_o.final_element),
    .run_length_o    (out_o.run_length)
  );

endmodule

// ----- sim/tb_top.sv -----
// Self-checking testbench for the longest increasing subsequence block.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam lis_pkg::val_t ValMin = lis_pkg::val_t'(32'h8000_0000);
  localparam lis_pkg::val_t ValMax = lis_pkg::val_t'(32'h7fff_ffff);
  localparam int unsigned MismatchShown = 10;
  localparam int unsigned LongHoldCycles = 500;

  typedef struct packed {
    lis_pkg::val_t element;
    logic          final_element;
    lis_pkg::cnt_t run_length;
  } lis_beat_t;

  class lis_scoreboard;
    lis_pkg::val_t seq_val[lis_pkg::MaxItems];
    int unsigned   chain_len[lis_pkg::MaxItems];
    int unsigned   back_link[lis_pkg::MaxItems];
    bit            has_link[lis_pkg::MaxItems];
    int unsigned   held;
    lis_beat_t     expect_q[$];
    int unsigned   mismatches;
    int unsigned   predicted;

    function new();
      held = 0;
      mismatches = 0;
      predicted = 0;
    endfunction

    function void flag(string what, lis_beat_t want, lis_beat_t got);
      mismatches++;
      if (mismatches <= MismatchShown) begin
        $display("%0t mismatch (%s): exp elem %0d last %0b len %0d",
                 $time, what, want.element, want.final_element, want.run_length);
        $display("    got elem %0d last %0b len %0d",
                 got.element, got.final_element, got.run_length);
      end
    endfunction

    function void note_input(lis_pkg::val_t v, logic fin);
      int unsigned   best;
      int unsigned   link;
      int unsigned   top;
      int unsigned   idx;
      int unsigned   n;
      bit            found;
      lis_pkg::val_t trail[$];
      lis_beat_t     b;
      if (held < lis_pkg::MaxItems) begin
        best = 0;
        link = 0;
        found = 1'b0;
        for (int k = int'(held) - 1; k >= 0; k--) begin
          if (chain_len[k] > best && seq_val[k] < v) begin
            best = chain_len[k];
            link = k;
            found = 1'b1;
          end
        end
        seq_val[held] = v;
        chain_len[held] = best + 1;
        back_link[held] = link;
        has_link[held] = found;
        held++;
      end
      if (!fin) return;
      best = 0;
      top = 0;
      for (int unsigned i = 0; i < held; i++) begin
        if (chain_len[i] > best) begin
          best = chain_len[i];
          top = i;
        end
      end
      idx = top;
      forever begin
        trail.push_front(seq_val[idx]);
        if (!has_link[idx] || trail.size() >= lis_pkg::MaxItems) break;
        idx = back_link[idx];
      end
      n = trail.size();
      for (int unsigned i = 0; i < n; i++) begin
        b.element = trail[i];
        b.final_element = (i == n - 1);
        b.run_length = lis_pkg::cnt_t'(n);
        expect_q = {expect_q, b};
      end
      predicted += n;
      held = 0;
    endfunction

    function void check_result(lis_pkg::val_t e, logic f, lis_pkg::cnt_t rl);
      lis_beat_t got;
      lis_beat_t want;
      got.element = e;
      got.final_element = f;
      got.run_length = rl;
      if (expect_q.size() == 0) begin
        want = '0;
        flag("unexpected beat", want, got);
        return;
      end
      want = expect_q.pop_front();
      if (want.element !== got.element) flag("element", want, got);
      else if (want.final_element !== got.final_element) flag("final_element", want, got);
      else if (want.run_length !== got.run_length) flag("run_length", want, got);
    endfunction

    function void settle();
      if (expect_q.size() != 0) begin
        mismatches++;
        $display("%0t %0d expected beats never arrived", $time, expect_q.size());
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  bit   hold_go;
  int unsigned burst_left;
  int unsigned rand_items;

  lis_scoreboard sb = new();

  lis_in_if  in_if();
  lis_out_if out_if();

  longest_increasing_subsequence DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_if.valid && in_if.ready) sb.note_input(in_if.value, in_if.is_final);
      if (out_if.valid && out_if.ready) begin
        sb.check_result(out_if.element, out_if.final_element, out_if.run_length);
      end
    end
  end

  initial begin : receiver
    int unsigned mode;
    int unsigned left;
    int unsigned hold_n;
    bit          hold_served;
    mode = 0;
    left = 0;
    hold_n = 0;
    hold_served = 1'b0;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_go && !hold_served) begin
        hold_served = 1'b1;
        hold_n = LongHoldCycles;
      end
      if (hold_n > 0) begin
        hold_n--;
        out_if.ready <= 1'b0;
      end else begin
        if (left == 0) begin
          mode = $urandom_range(0, 3);
          left = $urandom_range(8, 64);
        end
        left--;
        case (mode)
          0, 1: out_if.ready <= 1'b1;
          2: out_if.ready <= 1'($urandom_range(0, 1));
          default: out_if.ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  task automatic send_beat(input lis_pkg::val_t v, input logic fin);
    int unsigned gap;
    in_if.valid <= 1'b1;
    in_if.value <= v;
    in_if.is_final <= fin;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      burst_left = $urandom_range(1, 20);
      if (gap > 0) begin
        in_if.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  task automatic send_list(input lis_pkg::val_t vals[$]);
    foreach (vals[i]) send_beat(vals[i], i == vals.size() - 1);
  endtask

  function automatic lis_pkg::val_t pick_value(input int unsigned pos, input bit drift);
    int base;
    base = drift ? int'(pos) * 2 : 0;
    case ($urandom_range(0, 9))
      0: return ValMin;
      1: return ValMax;
      2, 3: return lis_pkg::val_t'($urandom);
      default: return lis_pkg::val_t'(base + int'($urandom_range(0, 24)) - 12);
    endcase
  endfunction

  task automatic send_random_seq(input int unsigned n);
    bit drift;
    drift = $urandom_range(0, 1);
    for (int unsigned i = 0; i < n; i++) begin
      send_beat(pick_value(i, drift), i == n - 1);
      rand_items++;
    end
  endtask

  task automatic wait_drained();
    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (sb.expect_q.size() != 0) @(posedge clk_i);
  endtask

  initial begin : stimulus
    lis_pkg::val_t dq[$];
    int unsigned   seq_n;
    rst_ni = 1'b0;
    hold_go = 1'b0;
    burst_left = 0;
    rand_items = 0;
    in_if.valid <= 1'b0;
    in_if.value <= '0;
    in_if.is_final <= 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    dq = {ValMin};
    send_list(dq);
    dq = {ValMax, ValMin};
    send_list(dq);
    dq = {lis_pkg::val_t'(5), lis_pkg::val_t'(5), lis_pkg::val_t'(5)};
    send_list(dq);
    dq = {lis_pkg::val_t'(2), lis_pkg::val_t'(1), lis_pkg::val_t'(3)};
    send_list(dq);
    dq = {lis_pkg::val_t'(1), lis_pkg::val_t'(3), lis_pkg::val_t'(2)};
    send_list(dq);
    dq = {ValMin, lis_pkg::val_t'(-1), lis_pkg::val_t'(0), lis_pkg::val_t'(1), ValMax};
    send_list(dq);
    dq = {lis_pkg::val_t'(32'haaaa_aaaa), lis_pkg::val_t'(32'h5555_5555),
          lis_pkg::val_t'(-9), lis_pkg::val_t'(10)};
    send_list(dq);
    wait_drained();

    seq_n = 0;
    while (rand_items < 125) begin
      if (seq_n == 2) hold_go = 1'b1;
      if (seq_n == 0) begin
        send_random_seq($urandom_range(lis_pkg::MaxItems + 1, lis_pkg::MaxItems + 8));
      end else if ($urandom_range(0, 15) == 0) begin
        send_random_seq(lis_pkg::MaxItems);
      end else begin
        send_random_seq($urandom_range(1, 16));
      end
      if (seq_n == 5) wait_drained();
      seq_n++;
    end

    wait_drained();
    repeat (100) @(posedge clk_i);
    sb.settle();
    if (sb.mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin : watchdog
    #10ms;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/lis_pkg.sv
rtl/lis_in_if.sv
rtl/lis_out_if.sv
rtl/lis_ram.sv
rtl/lis_dp.sv
rtl/lis_ctrl.sv
rtl/longest_increasing_subsequence.sv
sim/tb_top.sv
